// ===== src/u8vhe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared command type, escape phase codes and byte classification helpers.
// ----------------------------------------------------------------------------
package u8vhe_pkg;

	// Number of output units one input can cause: up to three held bytes plus the current one.
	localparam int UNITS = 4;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// Phases of a three-byte escape sequence.
	localparam logic [1:0] PH_BSL = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_LO  = 2'd2;

	// One command from the front end: a list of units, each a plain or an escaped byte.
	typedef struct packed {
		logic [UNITS-1:0][7:0] bytes;
		logic [UNITS-1:0]      esc;
		logic [2:0]            n;
	} cmd_t;

	// Upper-case hexadecimal digit for a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'h0, v};
		end else begin
			r = 8'h37 + {4'h0, v};
		end
		return r;
	endfunction

	// A byte that can never start a character: NUL, bare continuations, overlong and
	// out-of-range leads.
	function automatic logic start_bad(input logic [7:0] b);
		return (b == 8'h00) || ((b >= 8'h80) && (b <= 8'hC1)) || (b >= 8'hF5);
	endfunction

	// A byte that starts a multi-byte character.
	function automatic logic start_lead(input logic [7:0] b);
		return (b >= 8'hC2) && (b <= 8'hF4);
	endfunction

	// Total length of the character started by a lead byte.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		if (b < 8'hE0) begin
			r = 3'd2;
		end else if (b < 8'hF0) begin
			r = 3'd3;
		end else begin
			r = 3'd4;
		end
		return r;
	endfunction

	// Whether a byte may follow the held bytes; the first continuation after
	// some leads has a narrower range.
	function automatic logic cont_ok(input logic first, input logic [7:0] lead,
			input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (first) begin
			unique case (lead)
				8'hE0: lo = 8'hA0;
				8'hED: hi = 8'h9F;
				8'hF0: lo = 8'h90;
				8'hF4: hi = 8'h8F;
				default: begin
				end
			endcase
		end
		return (b >= lo) && (b <= hi);
	endfunction

endpackage

// ===== src/u8vhe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator front end
// Holds partial characters, classifies each incoming byte and, for each input
// with bytes to emit, issues a command that lists them and which to escape.
// ----------------------------------------------------------------------------
module u8vhe_front import u8vhe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [2:0][7:0] held_q;
	logic [2:0][7:0] held_d;
	logic [1:0]      cnt_q;
	logic [1:0]      cnt_d;
	logic [2:0]      need_q;
	logic [2:0]      need_d;
	logic [2:0]      cnt3;
	logic            b_bad;
	logic            b_lead;
	logic            b_ok;

	assign cnt3   = {1'b0, cnt_q};
	assign b_bad  = start_bad(data_byte);
	assign b_lead = start_lead(data_byte);
	assign b_ok   = cont_ok(cnt_q == 2'd1, held_q[0], data_byte);

	// Classify the transaction and work out the command and the next held state.
	always_comb begin
		held_d = held_q;
		cnt_d  = cnt_q;
		need_d = need_q;
		for (int i = 0; i < UNITS - 1; i++) begin
			cmd.bytes[i] = (3'(i) < cnt3) ? held_q[i] : data_byte;
		end
		cmd.bytes[UNITS-1] = data_byte;
		cmd.esc = '1;
		cmd.n   = 3'd0;
		if (kind) begin
			// End of stream: escape whatever is held.
			cmd.n  = cnt3;
			cnt_d  = 2'd0;
			need_d = 3'd0;
		end else if ((cnt_q != 2'd0) && b_ok) begin
			if ((cnt3 + 3'd1) >= need_q) begin
				// Character complete: emit it all unchanged.
				cmd.esc = '0;
				cmd.n   = cnt3 + 3'd1;
				cnt_d   = 2'd0;
				need_d  = 3'd0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (cnt_q == 2'(i)) begin
						held_d[i] = data_byte;
					end
				end
				cnt_d = cnt_q + 2'd1;
			end
		end else begin
			// New start, possibly after escaping a broken held sequence.
			for (int i = 0; i < UNITS; i++) begin
				cmd.esc[i] = (3'(i) < cnt3) ? 1'b1 : b_bad;
			end
			if (b_lead) begin
				cmd.n     = cnt3;
				held_d[0] = data_byte;
				cnt_d     = 2'd1;
				need_d    = lead_len(data_byte);
			end else begin
				cmd.n  = cnt3 + 3'd1;
				cnt_d  = 2'd0;
				need_d = 3'd0;
			end
		end
	end

	assign cmd_push = take && (cmd.n != 3'd0);

	// Held character state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= 2'd0;
			need_q <= 3'd0;
		end else if (take) begin
			held_q <= held_d;
			cnt_q  <= cnt_d;
			need_q <= need_d;
		end
	end

endmodule

// ===== src/u8vhe_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator command queue
// Small first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module u8vhe_cmd_fifo import u8vhe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (fill_q == CW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/u8vhe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator back end
// Walks each command one output byte per cycle while the output is free and
// expands escapes to a backslash and two hex digits, counts them, saturating.
// ----------------------------------------------------------------------------
module u8vhe_back import u8vhe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        cmd_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_escape,
	output logic [31:0] escape_count,
	output logic        last
);

	logic [1:0]  unit_q;
	logic [1:0]  ph_q;
	logic [31:0] cnt_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        esc_q;
	logic [31:0] ecnt_q;
	logic        last_q;

	logic        adv;
	logic [7:0]  cur_byte;
	logic        cur_esc;
	logic        unit_done;
	logic        final_res;
	logic [7:0]  res_byte;
	logic [31:0] cnt_d;

	assign adv       = head_valid && (!ov_q || pop);
	assign cur_byte  = head_cmd.bytes[unit_q];
	assign cur_esc   = head_cmd.esc[unit_q];
	assign unit_done = !cur_esc || (ph_q == PH_LO);
	assign final_res = unit_done && (({1'b0, unit_q} + 3'd1) == head_cmd.n);
	assign cmd_pop   = adv && final_res;

	// Byte for the current phase of the current unit.
	always_comb begin
		res_byte = cur_byte;
		if (cur_esc) begin
			unique case (ph_q)
				PH_BSL: res_byte = BACKSLASH;
				PH_HI:  res_byte = hex_digit(cur_byte[7:4]);
				PH_LO:  res_byte = hex_digit(cur_byte[3:0] & NIBBLE_MASK);
				default: res_byte = BACKSLASH;
			endcase
		end
	end

	// The count steps once per escape, on its backslash, and saturates.
	always_comb begin
		cnt_d = cnt_q;
		if (cur_esc && (ph_q == PH_BSL) && (cnt_q != '1)) begin
			cnt_d = cnt_q + 32'd1;
		end
	end

	// Sequencing through units and escape phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= 2'd0;
			ph_q   <= PH_BSL;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				cnt_q <= cnt_d;
				if (final_res) begin
					unit_q <= 2'd0;
					ph_q   <= PH_BSL;
				end else if (unit_done) begin
					unit_q <= unit_q + 2'd1;
					ph_q   <= PH_BSL;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= res_byte;
			esc_q  <= cur_esc;
			ecnt_q <= cnt_d;
			last_q <= final_res;
		end
	end

	assign empty        = !ov_q;
	assign out_byte     = byte_q;
	assign is_escape    = esc_q;
	assign escape_count = ecnt_q;
	assign last         = last_q;

endmodule

// ===== src/utf8_validate_hex_escape_core.sv =====
`timescale 1ns / 1ps
// An input's command is queued first; its first result is then held in the output register.
// One input per cycle is taken while the command queue has room; the back end emits
// one result per cycle while its output is free or popped, zero to twelve per input.
// The output port and the single-byte back end set the sustained rate.
// Reset clears held bytes, the escape count, the queue and the output valid flag.
// ----------------------------------------------------------------------------
// UTF-8 validator with backslash-hex escape
// Validates a UTF-8 byte stream and replaces bad bytes with hex escapes.
// ----------------------------------------------------------------------------
module utf8_validate_hex_escape_core import u8vhe_pkg::*; #(
	parameter int CMD_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_escape,
	output logic [31:0] escape_count,
	output logic        last
);

	logic take;
	logic cmd_push;
	cmd_t cmd;
	logic cmd_pop;
	logic head_valid;
	cmd_t head_cmd;

	// An input transaction completes whenever the queue has room.
	assign take = push && !full;

	u8vhe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.kind      (kind),
		.data_byte (data_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	u8vhe_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.wr_cmd     (cmd),
		.full       (full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	u8vhe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.is_escape    (is_escape),
		.escape_count (escape_count),
		.last         (last)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator with hex escape: self-checking testbench
// A table of directed bytes is followed by random UTF-8 traffic, mostly well-formed
// characters with broken sequences, stray bytes and end-of-stream flushes mixed in.
// Every accepted input is run through a local model of the validator, and each
// output transaction is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
	import u8vhe_pkg::*;

	// Input kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	localparam int RANDOM_ITEMS = 480;
	localparam int TAIL_ITEMS   = 60;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AT      = 150;
	localparam int PAUSE_AT     = 320;
	localparam int DRAIN_LIMIT  = 50000;
	localparam int MAX_PRINTS   = 40;

	// One input transaction, with an optional hand-written expectation.
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        typed;
		logic        t_esc;
		logic [7:0]  t_hi;
		logic [7:0]  t_lo;
		logic [31:0] t_cnt;
	} row_t;

	// One output transaction.
	typedef struct packed {
		logic [7:0]  ch;
		logic        esc;
		logic [31:0] cnt;
		logic        fin;
	} out_t;

	// Directed stimulus. Rows marked typed carry their expected output; the rest
	// are checked against the model.
	localparam int N_DIRECTED = 30;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		// Plain ASCII straight after reset, and the top of the ASCII range.
		'{KIND_DATA, 8'h41, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h7F, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0},
		// Bytes that can never start a character.
		'{KIND_DATA, 8'h00, 1'b1, 1'b1, "0", "0", 32'd1},
		'{KIND_DATA, 8'h80, 1'b1, 1'b1, "8", "0", 32'd2},
		'{KIND_DATA, 8'hC1, 1'b1, 1'b1, "C", "1", 32'd3},
		'{KIND_DATA, 8'hF5, 1'b1, 1'b1, "F", "5", 32'd4},
		'{KIND_DATA, 8'hFF, 1'b1, 1'b1, "F", "F", 32'd5},
		'{KIND_DATA, 8'hF8, 1'b1, 1'b1, "F", "8", 32'd6},
		'{KIND_DATA, 8'hFC, 1'b1, 1'b1, "F", "C", 32'd7},
		// Smallest two-byte character.
		'{KIND_DATA, 8'hC2, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Overlong three-byte form.
		'{KIND_DATA, 8'hE0, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h9F, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Surrogate.
		'{KIND_DATA, 8'hED, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'hA0, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Overlong four-byte form.
		'{KIND_DATA, 8'hF0, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h8F, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Code point above the Unicode range.
		'{KIND_DATA, 8'hF4, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h90, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Highest valid code point.
		'{KIND_DATA, 8'hF4, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h8F, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'hBF, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'hBF, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// Three held bytes broken by a bad byte: the longest burst of output.
		'{KIND_DATA, 8'hF1, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		// End of stream with a lead held, then with nothing held.
		'{KIND_DATA, 8'hE1, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_EOS,  8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0},
		'{KIND_EOS,  8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        kind = KIND_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        is_escape;
	logic [31:0] escape_count;
	logic        last;

	utf8_validate_hex_escape_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.is_escape    (is_escape),
		.escape_count (escape_count),
		.last         (last)
	);

	always #1 clk = ~clk;

	// Model state of the validator.
	logic [7:0]  held [3];
	logic [1:0]  held_n;
	logic [2:0]  need_len;
	logic [31:0] esc_total;
	string       hex_chars = "0123456789ABCDEF";

	row_t stim_q [$];
	out_t step_bytes [$];
	out_t expected_bytes [$];

	int  bad_count;
	int  prints;
	int  accepted;
	int  eos_items;
	int  checked;
	int  escaped_seen;
	int  full_cycles;
	bit  tail;
	bit  long_hold_done;

	// Prints one line per mismatch, up to a cap, and counts all of them.
	task automatic report(input string msg);
		bad_count++;
		if (prints < MAX_PRINTS) begin
			prints++;
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	// ---------------------------------------------------------------- model

	function void put_ch(input logic [7:0] c, input logic e);
		step_bytes.push_back('{c, e, esc_total, 1'b0});
	endfunction

	// A bad byte becomes a backslash and two upper-case hex digits.
	function void put_escape(input logic [7:0] v);
		if (esc_total != 32'hFFFF_FFFF) begin
			esc_total = esc_total + 32'd1;
		end
		put_ch(BACKSLASH, 1'b1);
		put_ch(hex_chars[v[7:4]], 1'b1);
		put_ch(hex_chars[v[3:0]], 1'b1);
	endfunction

	function void escape_held_bytes();
		for (int i = 0; i < held_n; i++) begin
			put_escape(held[i]);
		end
		held_n = 2'd0;
		need_len = 3'd0;
	endfunction

	function void start_char(input logic [7:0] b);
		if (b == 8'h00 || (b >= 8'h80 && b <= 8'hC1) || b >= 8'hF5) begin
			put_escape(b);
		end else if (b < 8'h80) begin
			put_ch(b, 1'b0);
		end else begin
			held[0] = b;
			held_n = 2'd1;
			need_len = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
		end
	endfunction

	// Allowed range of the next continuation byte after a given lead.
	function void cont_range(input logic [7:0] lead, input bit first,
			output logic [7:0] lo, output logic [7:0] hi);
		lo = 8'h80;
		hi = 8'hBF;
		if (first) begin
			case (lead)
				8'hE0: lo = 8'hA0;
				8'hED: hi = 8'h9F;
				8'hF0: lo = 8'h90;
				8'hF4: hi = 8'h8F;
				default: begin
				end
			endcase
		end
	endfunction

	function void take_data(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		if (held_n == 2'd0) begin
			start_char(b);
		end else begin
			cont_range(held[0], held_n == 2'd1, lo, hi);
			if (b < lo || b > hi) begin
				escape_held_bytes();
				start_char(b);
			end else if ({1'b0, held_n} + 3'd1 >= need_len) begin
				for (int i = 0; i < held_n; i++) begin
					put_ch(held[i], 1'b0);
				end
				put_ch(b, 1'b0);
				held_n = 2'd0;
				need_len = 3'd0;
			end else begin
				held[held_n] = b;
				held_n = held_n + 2'd1;
			end
		end
	endfunction

	// Works out the output transactions caused by one input transaction.
	function void utf8_escape_predict(input logic k, input logic [7:0] b);
		step_bytes.delete();
		if (k == KIND_EOS) begin
			escape_held_bytes();
		end else begin
			take_data(b);
		end
		if (step_bytes.size() > 0) begin
			step_bytes[step_bytes.size() - 1].fin = 1'b1;
		end
	endfunction

	// Records an accepted input: the model always advances, and typed rows
	// supply their own expectation in place of the model's.
	function void accept_input(input row_t r);
		utf8_escape_predict(r.kind, r.data);
		accepted++;
		if (r.kind == KIND_EOS) begin
			eos_items++;
		end
		if (!r.typed) begin
			foreach (step_bytes[i]) begin
				expected_bytes.push_back(step_bytes[i]);
			end
		end else if (!r.t_esc) begin
			expected_bytes.push_back('{r.data, 1'b0, r.t_cnt, 1'b1});
		end else begin
			expected_bytes.push_back('{BACKSLASH, 1'b1, r.t_cnt, 1'b0});
			expected_bytes.push_back('{r.t_hi, 1'b1, r.t_cnt, 1'b0});
			expected_bytes.push_back('{r.t_lo, 1'b1, r.t_cnt, 1'b1});
		end
	endfunction

	// ------------------------------------------------------------- stimulus

	function void add_data(input logic [7:0] b);
		stim_q.push_back('{KIND_DATA, b, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0});
	endfunction

	function void add_eos();
		stim_q.push_back('{KIND_EOS, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
			8'h00, 8'h00, 32'd0});
	endfunction

	// Appends one random sequence: mostly whole characters, some broken ones.
	function void add_random_sequence();
		int         sel;
		int         n;
		int         conts;
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			add_data(8'($urandom_range(1, 127)));
		end else if (sel < 80) begin
			if (sel < 45) begin
				lead = 8'($urandom_range(8'hDF, 8'hC2));
			end else if (sel < 60) begin
				lead = 8'($urandom_range(8'hEF, 8'hE0));
			end else if (sel < 72) begin
				lead = 8'($urandom_range(8'hF4, 8'hF0));
			end else begin
				lead = 8'($urandom_range(8'hF4, 8'hC2));
			end
			n = (lead < 8'hE0) ? 2 : (lead < 8'hF0) ? 3 : 4;
			// Truncated sequences stop short and may be flushed.
			conts = (sel < 72) ? n - 1 : $urandom_range(0, n - 2);
			add_data(lead);
			for (int i = 1; i <= conts; i++) begin
				cont_range(lead, i == 1, lo, hi);
				add_data(8'($urandom_range(hi, lo)));
			end
			if (sel >= 72 && $urandom_range(0, 1) == 1) begin
				add_eos();
			end
		end else if (sel < 92) begin
			add_data(8'($urandom_range(0, 255)));
		end else if (sel < 96) begin
			// A lead followed at once by a byte outside its allowed range.
			lead = 8'($urandom_range(8'hF4, 8'hC2));
			cont_range(lead, 1'b1, lo, hi);
			add_data(lead);
			if ($urandom_range(0, 1) == 1) begin
				add_data(8'($urandom_range(lo - 8'd1, 0)));
			end else begin
				add_data(8'($urandom_range(255, hi + 8'd1)));
			end
		end else begin
			add_eos();
		end
	endfunction

	// ---------------------------------------------------------------- sender

	initial begin
		int   tx_gap;
		bit   paused;
		int   drain;
		row_t r;
		tx_gap = 0;
		paused = 1'b0;
		held = '{8'h00, 8'h00, 8'h00};
		held_n = 2'd0;
		need_len = 3'd0;
		esc_total = 32'd0;

		for (int i = 0; i < N_DIRECTED; i++) begin
			stim_q.push_back(DIRECTED[i]);
		end
		while (stim_q.size() < N_DIRECTED + RANDOM_ITEMS) begin
			add_random_sequence();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() > 0) begin
			@(negedge clk);
			tail = stim_q.size() < TAIL_ITEMS;
			if (!paused && accepted >= PAUSE_AT) begin
				// Let the block drain completely before carrying on.
				paused = 1'b1;
				push <= 1'b0;
				while (expected_bytes.size() != 0) begin
					@(negedge clk);
				end
				@(negedge clk);
			end
			r = stim_q[0];
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (!tail && !(long_hold_done && accepted < HOLD_AT + 40)
					&& $urandom_range(0, 7) == 0) begin
				tx_gap = $urandom_range(1, 13) - 1;
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				kind <= r.kind;
				data_byte <= r.data;
			end
			@(posedge clk);
			if (push && full) begin
				full_cycles++;
			end
			if (push && !full) begin
				accept_input(stim_q.pop_front());
			end
		end
		@(negedge clk);
		push <= 1'b0;

		// Wait for the last results, then keep waiting for anything stray.
		drain = 0;
		while (expected_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			report($sformatf("%0d expected results never arrived",
				expected_bytes.size()));
		end

		$display("Covered %0d input transactions (%0d end-of-stream) and checked %0d results,",
			accepted, eos_items, checked);
		$display("%0d of them escape bytes; final escape count %0d; input held off %0d cycles.",
			escaped_seen, esc_total, full_cycles);
		if (bad_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// -------------------------------------------------------------- receiver

	initial begin
		int   rx_gap;
		int   hold_left;
		out_t w;
		rx_gap = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!long_hold_done && accepted >= HOLD_AT) begin
				// Long hold-off so that the block fills and stalls its input.
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else if (!tail && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 13) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				checked++;
				if (is_escape === 1'b1) begin
					escaped_seen++;
				end
				if (expected_bytes.size() == 0) begin
					report($sformatf("unexpected result out_byte=%02h", out_byte));
				end else begin
					w = expected_bytes.pop_front();
					if (out_byte !== w.ch) begin
						report($sformatf("out_byte %02h, want %02h", out_byte, w.ch));
					end
					if (is_escape !== w.esc) begin
						report($sformatf("is_escape %b, want %b", is_escape, w.esc));
					end
					if (escape_count !== w.cnt) begin
						report($sformatf("escape_count %0d, want %0d",
							escape_count, w.cnt));
					end
					if (last !== w.fin) begin
						report($sformatf("last %b, want %b", last, w.fin));
					end
				end
			end
		end
	end

	// Overall limit on the run.
	initial begin
		#2_000_000;
		$display("Run timed out");
		$display("Mismatches found");
		$finish;
	end

endmodule
